// ----- rtl/fvhc_pkg.sv -----
// shared types and constants for the heat-map color pipeline
package fvhc_pkg;

    // quotient and channel widths
    localparam int QUOT_W     = 8;
    localparam int DIV_STAGES = 4;
    localparam int DIV_BITS   = QUOT_W / DIV_STAGES;
    localparam int SEG_STAGES = 2;
    localparam int PIPE_DEPTH = SEG_STAGES + DIV_STAGES + 1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX    = 3'd4;

    // reset breakpoints in q7.8
    localparam int RST_MIN  = -7680;
    localparam int RST_LOW  = -6400;
    localparam int RST_HIGH = -5120;
    localparam int RST_MAX  = -2560;

    localparam logic [QUOT_W-1:0] CH_FULL = 8'd255;
    localparam logic [QUOT_W-1:0] CH_OFF  = 8'd0;

    // which color region an item falls into
    typedef enum logic [2:0] {
        CLS_WHITE,
        CLS_BLUE,
        CLS_RED,
        CLS_SEG0,
        CLS_SEG1,
        CLS_SEG2,
        CLS_SEG3
    } cls_t;

    // how the segment fraction is formed
    typedef enum logic [1:0] {
        FRAC_ZERO,
        FRAC_FULL,
        FRAC_DIV
    } frac_t;

    typedef struct packed {
        cls_t  cls;
        frac_t frac;
    } tag_t;

endpackage

// ----- rtl/fvhc_seg.sv -----
// segment selection and dividend preparation, two pipeline stages
module fvhc_seg
    import fvhc_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic [SEG_STAGES-1:0]         stage_en,
    input  logic signed [VALUE_WIDTH-1:0] flow_level,
    input  logic                          color_enable,
    input  logic signed [VALUE_WIDTH-1:0] range_min,
    input  logic signed [VALUE_WIDTH-1:0] range_low,
    input  logic signed [VALUE_WIDTH-1:0] range_high,
    input  logic signed [VALUE_WIDTH-1:0] range_max,
    output tag_t                          tag,
    output logic [VALUE_WIDTH+QUOT_W-1:0] num,
    output logic [VALUE_WIDTH-1:0]        den
);

    localparam int W = VALUE_WIDTH;

    logic signed [W:0]   mid_sum;
    logic signed [W-1:0] mid;
    cls_t                cls_next;
    logic signed [W-1:0] start_next;
    logic signed [W-1:0] end_next;

    cls_t                cls_reg;
    logic signed [W-1:0] v_reg;
    logic signed [W-1:0] start_reg;
    logic signed [W-1:0] end_reg;

    logic                zero_c;
    logic                full_c;
    logic [W:0]          d_c;
    logic [W:0]          len_c;
    tag_t                tag_next;
    logic [W+QUOT_W-1:0] num_next;

    tag_t                tag_reg;
    logic [W+QUOT_W-1:0] num_reg;
    logic [W-1:0]        den_reg;

    // midpoint of low and high, rounded up
    always_comb
    begin
        mid_sum = {range_low[W-1], range_low} + {range_high[W-1], range_high}
                  + (W+1)'(1);
        mid     = mid_sum[W:1];
    end

    // stage one: pick the region and its end points
    always_comb
    begin
        start_next = range_min;
        end_next   = range_low;
        if (!color_enable)
        begin
            cls_next = CLS_WHITE;
        end
        else if (flow_level < range_min)
        begin
            cls_next = CLS_BLUE;
        end
        else if (flow_level >= range_max)
        begin
            cls_next = CLS_RED;
        end
        else if (flow_level < range_low)
        begin
            cls_next = CLS_SEG0;
        end
        else if (flow_level >= range_high)
        begin
            cls_next   = CLS_SEG3;
            start_next = range_high;
            end_next   = range_max;
        end
        else if (flow_level < mid)
        begin
            cls_next   = CLS_SEG1;
            start_next = range_low;
            end_next   = mid;
        end
        else
        begin
            cls_next   = CLS_SEG2;
            start_next = mid;
            end_next   = range_high;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            cls_reg   <= cls_next;
            v_reg     <= flow_level;
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

    // stage two: saturation tests and dividend 255 * (v - start)
    always_comb
    begin
        zero_c   = (end_reg <= start_reg) || (v_reg <= start_reg);
        full_c   = (v_reg >= end_reg);
        d_c      = {v_reg[W-1], v_reg} - {start_reg[W-1], start_reg};
        len_c    = {end_reg[W-1], end_reg} - {start_reg[W-1], start_reg};
        num_next = {d_c[W-1:0], {QUOT_W{1'b0}}} - {{QUOT_W{1'b0}}, d_c[W-1:0]};
        tag_next.cls = cls_reg;
        if (zero_c)
        begin
            tag_next.frac = FRAC_ZERO;
        end
        else if (full_c)
        begin
            tag_next.frac = FRAC_FULL;
        end
        else
        begin
            tag_next.frac = FRAC_DIV;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            tag_reg <= tag_next;
            num_reg <= num_next;
            den_reg <= len_c[W-1:0];
        end
    end

    assign tag = tag_reg;
    assign num = num_reg;
    assign den = den_reg;

endmodule

// ----- rtl/fvhc_div.sv -----
// pipelined restoring divider, two quotient bits per stage
module fvhc_div
    import fvhc_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic [DIV_STAGES-1:0]         stage_en,
    input  tag_t                          tag_in,
    input  logic [VALUE_WIDTH+QUOT_W-1:0] num,
    input  logic [VALUE_WIDTH-1:0]        den,
    output tag_t                          tag_out,
    output logic [QUOT_W-1:0]             quot
);

    localparam int NUM_W = VALUE_WIDTH + QUOT_W;

    tag_t                   tag_reg  [DIV_STAGES];
    logic [NUM_W-1:0]       rem_reg  [DIV_STAGES];
    logic [VALUE_WIDTH-1:0] den_reg  [DIV_STAGES];
    logic [QUOT_W-1:0]      q_reg    [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            tag_t                   tag_src;
            logic [NUM_W-1:0]       rem_src;
            logic [VALUE_WIDTH-1:0] den_src;
            logic [QUOT_W-1:0]      q_src;
            logic [NUM_W-1:0]       rem_next;
            logic [QUOT_W-1:0]      q_next;

            // operands from the previous stage
            if (k == 0)
            begin : g_first
                assign tag_src = tag_in;
                assign rem_src = num;
                assign den_src = den;
                assign q_src   = '0;
            end
            else
            begin : g_rest
                assign tag_src = tag_reg[k-1];
                assign rem_src = rem_reg[k-1];
                assign den_src = den_reg[k-1];
                assign q_src   = q_reg[k-1];
            end

            // trial subtract of the shifted divisor, msb first
            always_comb
            begin
                logic [NUM_W-1:0] trial;
                int               bit_pos;
                rem_next = rem_src;
                q_next   = q_src;
                for (int j = 0; j < DIV_BITS; j++)
                begin
                    bit_pos = QUOT_W - 1 - k * DIV_BITS - j;
                    trial   = {{QUOT_W{1'b0}}, den_src} << bit_pos;
                    if (rem_next >= trial)
                    begin
                        rem_next        = rem_next - trial;
                        q_next[bit_pos] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_en[k])
                begin
                    tag_reg[k] <= tag_src;
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_src;
                    q_reg[k]   <= q_next;
                end
            end
        end
    endgenerate

    assign tag_out = tag_reg[DIV_STAGES-1];
    assign quot    = q_reg[DIV_STAGES-1];

endmodule

// ----- rtl/flow_value_heatmap_color_core.sv -----
// top level of the five-stop heat-map color pipeline
//
//  channel   direction  handshake            payload
//  flow      in         flow_valid/stall     flow_level
//  color     out        color_valid/stall    red, green, blue
//  cfg       in         cfg_valid/ready      cfg_index, cfg_data
//
// one item per cycle unless the output stalls, through segment selection and
// dividend setup, the divider at two quotient bits per stage, and one
// output register. each stage loads when it is empty or the next one
// moves, so bubbles close up under a stalled output. reset clears all
// valid bits and loads the default breakpoints; cfg_ready is always high.
module flow_value_heatmap_color_core
    import fvhc_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          flow_valid,
    output logic                          flow_stall,
    input  logic signed [VALUE_WIDTH-1:0] flow_level,
    output logic                          color_valid,
    input  logic                          color_stall,
    output logic [QUOT_W-1:0]             red,
    output logic [QUOT_W-1:0]             green,
    output logic [QUOT_W-1:0]             blue,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [VALUE_WIDTH-1:0]        cfg_data
);

    localparam int OUT_STAGE = PIPE_DEPTH - 1;

    logic                          enable_reg;
    logic signed [VALUE_WIDTH-1:0] min_reg;
    logic signed [VALUE_WIDTH-1:0] low_reg;
    logic signed [VALUE_WIDTH-1:0] high_reg;
    logic signed [VALUE_WIDTH-1:0] max_reg;

    logic [PIPE_DEPTH-1:0] stage_en;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;

    tag_t                          seg_tag;
    logic [VALUE_WIDTH+QUOT_W-1:0] seg_num;
    logic [VALUE_WIDTH-1:0]        seg_den;
    tag_t                          div_tag;
    logic [QUOT_W-1:0]             div_quot;

    logic [QUOT_W-1:0] frac;
    logic [QUOT_W-1:0] red_next;
    logic [QUOT_W-1:0] green_next;
    logic [QUOT_W-1:0] blue_next;
    logic [QUOT_W-1:0] red_reg;
    logic [QUOT_W-1:0] green_reg;
    logic [QUOT_W-1:0] blue_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            min_reg    <= VALUE_WIDTH'(RST_MIN);
            low_reg    <= VALUE_WIDTH'(RST_LOW);
            high_reg   <= VALUE_WIDTH'(RST_HIGH);
            max_reg    <= VALUE_WIDTH'(RST_MAX);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_MIN:    min_reg    <= cfg_data;
                REG_LOW:    low_reg    <= cfg_data;
                REG_HIGH:   high_reg   <= cfg_data;
                REG_MAX:    max_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    // stage enables ripple back from the output
    always_comb
    begin
        stage_en[OUT_STAGE] = !valid_reg[OUT_STAGE] || !color_stall;
        for (int k = OUT_STAGE - 1; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    // valid bits travel with the data
    always_comb
    begin
        valid_next[0] = stage_en[0] ? flow_valid : valid_reg[0];
        for (int k = 1; k < PIPE_DEPTH; k++)
        begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign flow_stall = !stage_en[0];

    fvhc_seg #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seg (
        .clk          (clk),
        .stage_en     (stage_en[SEG_STAGES-1:0]),
        .flow_level   (flow_level),
        .color_enable (enable_reg),
        .range_min    (min_reg),
        .range_low    (low_reg),
        .range_high   (high_reg),
        .range_max    (max_reg),
        .tag          (seg_tag),
        .num          (seg_num),
        .den          (seg_den)
    );

    fvhc_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .stage_en (stage_en[SEG_STAGES +: DIV_STAGES]),
        .tag_in   (seg_tag),
        .num      (seg_num),
        .den      (seg_den),
        .tag_out  (div_tag),
        .quot     (div_quot)
    );

    // fraction and channel mix for the region
    always_comb
    begin
        case (div_tag.frac)
            FRAC_ZERO: frac = CH_OFF;
            FRAC_FULL: frac = CH_FULL;
            FRAC_DIV:  frac = div_quot;
            default:   frac = CH_OFF;
        endcase

        case (div_tag.cls)
            CLS_WHITE:
            begin
                red_next = CH_FULL; green_next = CH_FULL; blue_next = CH_FULL;
            end
            CLS_BLUE:
            begin
                red_next = CH_OFF; green_next = CH_OFF; blue_next = CH_FULL;
            end
            CLS_RED:
            begin
                red_next = CH_FULL; green_next = CH_OFF; blue_next = CH_OFF;
            end
            CLS_SEG0:
            begin
                red_next = CH_OFF; green_next = frac; blue_next = CH_FULL;
            end
            CLS_SEG1:
            begin
                red_next = CH_OFF; green_next = CH_FULL; blue_next = CH_FULL - frac;
            end
            CLS_SEG2:
            begin
                red_next = frac; green_next = CH_FULL; blue_next = CH_OFF;
            end
            CLS_SEG3:
            begin
                red_next = CH_FULL; green_next = CH_FULL - frac; blue_next = CH_OFF;
            end
            default:
            begin
                red_next = CH_FULL; green_next = CH_FULL; blue_next = CH_FULL;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (stage_en[OUT_STAGE])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign color_valid = valid_reg[OUT_STAGE];
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;

endmodule

// ----- rtl/fvhc_checker.sv -----
// port-level checks for the heat-map color core and their bind
module fvhc_checker
    import fvhc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              flow_stall,
    input logic              color_valid,
    input logic              color_stall,
    input logic [QUOT_W-1:0] red,
    input logic [QUOT_W-1:0] green,
    input logic [QUOT_W-1:0] blue
);

    // a stalled item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && color_stall |=> color_valid)
        else $error("color item dropped while stalled");

    // a stalled item keeps its color
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && color_stall |=> $stable(red) && $stable(green) && $stable(blue))
        else $error("color payload changed while stalled");

    // input only backs up when the whole pipe is full and blocked
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        flow_stall |-> color_valid && color_stall)
        else $error("input stalled with room in the pipeline");

    // every ramp color or white has a saturated channel
    a_has_full: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid |-> red == CH_FULL || green == CH_FULL || blue == CH_FULL)
        else $error("color with no saturated channel");

    // only white has neither red nor blue off
    a_white_only: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid |-> red == CH_OFF || blue == CH_OFF ||
            (red == CH_FULL && green == CH_FULL && blue == CH_FULL))
        else $error("color outside the ramp");

endmodule

bind flow_value_heatmap_color_core fvhc_checker u_fvhc_checker (.*);
